### sv/mkey_pkg.sv
// Shared types, constants and the symbol code table for the Morse keyer.
// No dependencies; used by every module of the keyer.
package mkey_pkg;

  localparam int CHAR_W     = 8;
  localparam int UNITS_W    = 3;
  localparam int UNIT_MS_W  = 8;
  localparam int DUR_W      = 10;
  localparam int IDX_W      = 6;
  localparam int CODE_W     = 8;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 32;

  localparam logic [UNIT_MS_W-1:0] UNIT_MS_RESET = 8'd60;
  localparam logic [CFG_AW-1:0]    REG_UNIT_MS   = 2'd0;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_FOLD    = 8'h20;

  localparam logic [UNITS_W-1:0] U_DOT    = 3'd1;
  localparam logic [UNITS_W-1:0] U_DASH   = 3'd3;
  localparam logic [UNITS_W-1:0] U_GAP    = 3'd1;
  localparam logic [UNITS_W-1:0] U_LETTER = 3'd2;
  localparam logic [UNITS_W-1:0] U_WORD   = 3'd4;

  // One key segment before its length in milliseconds is known
  typedef struct packed {
    logic               tone;
    logic [UNITS_W-1:0] units;
    logic               last;
  } seg_t;

  // Symbol codes, LSB first, 1 = dash, highest 1 bit marks the end
  function automatic logic [CODE_W-1:0] sym_code(input logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] c;
    case (idx)
      6'd12: c = 8'd115;
      6'd13: c = 8'd49;
      6'd14: c = 8'd106;
      6'd15: c = 8'd41;
      6'd16: c = 8'd63;
      6'd17: c = 8'd62;
      6'd18: c = 8'd60;
      6'd19: c = 8'd56;
      6'd20: c = 8'd48;
      6'd21: c = 8'd32;
      6'd22: c = 8'd33;
      6'd23: c = 8'd35;
      6'd24: c = 8'd39;
      6'd25: c = 8'd47;
      6'd31: c = 8'd76;
      6'd33: c = 8'd6;
      6'd34: c = 8'd17;
      6'd35: c = 8'd21;
      6'd36: c = 8'd9;
      6'd37: c = 8'd2;
      6'd38: c = 8'd20;
      6'd39: c = 8'd11;
      6'd40: c = 8'd16;
      6'd41: c = 8'd4;
      6'd42: c = 8'd30;
      6'd43: c = 8'd13;
      6'd44: c = 8'd18;
      6'd45: c = 8'd7;
      6'd46: c = 8'd5;
      6'd47: c = 8'd15;
      6'd48: c = 8'd22;
      6'd49: c = 8'd27;
      6'd50: c = 8'd10;
      6'd51: c = 8'd8;
      6'd52: c = 8'd3;
      6'd53: c = 8'd12;
      6'd54: c = 8'd24;
      6'd55: c = 8'd14;
      6'd56: c = 8'd25;
      6'd57: c = 8'd29;
      6'd58: c = 8'd19;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### sv/mkey_dur.sv
// Segment length in milliseconds: units times unit_ms by shift and add.
// Depends on mkey_pkg.
module mkey_dur (
  input  logic [mkey_pkg::UNITS_W-1:0]   units,
  input  logic [mkey_pkg::UNIT_MS_W-1:0] unit_ms,
  output logic [mkey_pkg::DUR_W-1:0]     duration_ms
);
  import mkey_pkg::*;

  logic [DUR_W-1:0] base;

  // Add the shifted unit length for each set bit of units
  always_comb begin
    base        = DUR_W'(unit_ms);
    duration_ms = (units[0] ? base : '0)
                + (units[1] ? DUR_W'(base << 1) : '0)
                + (units[2] ? DUR_W'(base << 2) : '0);
  end

endmodule

### sv/mkey_seq.sv
// Sequencer that walks a character's symbol code and issues key segments.
// Depends on mkey_pkg.
module mkey_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mkey_pkg::CHAR_W-1:0]   char_code,
  input  logic                          adv,
  output logic                          idle,
  output logic                          seg_valid,
  output mkey_pkg::seg_t                seg
);
  import mkey_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SYM  = 5'b00010,
    ST_GAP  = 5'b00100,
    ST_END  = 5'b01000,
    ST_SPC  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;

  logic [CHAR_W-1:0] folded;
  logic [CHAR_W-1:0] idx_wide;
  logic              char_ok;
  logic [CODE_W-1:0] lut_code;
  logic [CODE_W-1:0] code_shift;

  // Fold case and range-check the request
  always_comb begin
    folded   = (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) ?
               char_code - CH_FOLD : char_code;
    char_ok  = !char_code[CHAR_W-1] && char_code >= CH_SPACE && folded <= CH_UPPER_Z;
    idx_wide = folded - CH_SPACE;
    lut_code = sym_code(idx_wide[IDX_W-1:0]);
    code_shift = code_r >> 1;
  end

  // Next state and segment to issue
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    seg_valid = 1'b0;
    seg       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start && char_ok) begin
          code_nxt = lut_code;
          if (idx_wide == '0) begin
            state_nxt = ST_SPC;
          end else if ((lut_code & 8'hFE) != '0) begin
            state_nxt = ST_SYM;
          end else begin
            state_nxt = ST_END;
          end
        end
      end
      ST_SYM: begin
        seg_valid  = 1'b1;
        seg.tone   = 1'b1;
        seg.units  = code_r[0] ? U_DASH : U_DOT;
        if (adv) state_nxt = ST_GAP;
      end
      ST_GAP: begin
        seg_valid = 1'b1;
        seg.units = U_GAP;
        if (adv) begin
          code_nxt  = code_shift;
          state_nxt = ((code_shift & 8'hFE) != '0) ? ST_SYM : ST_END;
        end
      end
      ST_END: begin
        seg_valid = 1'b1;
        seg.units = U_LETTER;
        seg.last  = 1'b1;
        if (adv) state_nxt = ST_IDLE;
      end
      ST_SPC: begin
        seg_valid = 1'b1;
        seg.units = U_WORD;
        seg.last  = 1'b1;
        if (adv) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign idle = (state_r == ST_IDLE);

  // Hold state and remaining code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    code_r <= code_nxt;
  end

endmodule

### sv/morse_keyer_core.sv
// Top level of the Morse keyer: stream ports, APB register and output stage.
// Depends on mkey_pkg, mkey_seq and mkey_dur.
//
// Each character request gives a run of key segments, one per cycle while the
// result side takes them. Once a request is taken, a letter with
// k symbols issues 2k+1 segments (at most 13), a space issues one and a byte
// outside space..'Z' (after folding lower case) issues none. The sequencer
// walks the symbol code one bit per two segments and takes no new request
// until the run is done. Each segment's millisecond length comes from a
// shift-and-add unit shared by all segments. unit_ms at byte address 0
// resets to UNIT_MS_INIT, 60 by default.
module morse_keyer_core #(
  parameter logic [mkey_pkg::UNIT_MS_W-1:0] UNIT_MS_INIT = mkey_pkg::UNIT_MS_RESET
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: char_code[7:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mkey_pkg::CHAR_W-1:0]       in_tdata,
  // out_tdata: tone_on[0], units[3:1], duration_ms[13:4], zero [15:14]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mkey_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mkey_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [mkey_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [mkey_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import mkey_pkg::*;

  logic [UNIT_MS_W-1:0] unit_ms_r;
  logic                 seq_idle;
  logic                 seg_valid;
  seg_t                 seg;
  logic                 adv;
  logic [DUR_W-1:0]     dur;

  logic                 out_valid_r;
  logic                 out_tone_r;
  logic [UNITS_W-1:0]   out_units_r;
  logic [DUR_W-1:0]     out_dur_r;
  logic                 out_last_r;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_UNIT_MS) ? CFG_DW'(unit_ms_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ms_r <= UNIT_MS_INIT;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_UNIT_MS) begin
      unit_ms_r <= cfg_pwdata[UNIT_MS_W-1:0];
    end
  end

  // Advance the sequencer when the output stage is free
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = seq_idle;

  mkey_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && in_tready),
    .char_code (in_tdata),
    .adv       (adv),
    .idle      (seq_idle),
    .seg_valid (seg_valid),
    .seg       (seg)
  );

  mkey_dur u_dur (
    .units       (seg.units),
    .unit_ms     (unit_ms_r),
    .duration_ms (dur)
  );

  // Output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= seg_valid;
    end
    if (adv && seg_valid) begin
      out_tone_r  <= seg.tone;
      out_units_r <= seg.units;
      out_dur_r   <= dur;
      out_last_r  <= seg.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_dur_r, out_units_r, out_tone_r};
  assign out_tlast  = out_last_r;

endmodule

### tb/morse_keyer_core_tb.sv
// Self-checking testbench for morse_keyer_core: character stream in, key segments out.
// Depends on mkey_pkg and morse_keyer_core; a directed table runs first, then
// random text with random stalls on both streams.
module morse_keyer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mkey_pkg::*;

  localparam int                NUM_CODES      = 59;
  localparam int                SETTLE_CYCLES  = 20;
  localparam int                CYCLE_LIMIT    = 500000;
  localparam int                ITEMS_PER_RUN  = 70;
  localparam int                NUM_RUNS       = 6;
  localparam logic [CFG_AW-1:0] REG_UNMAPPED   = 2'd3;

  typedef struct packed {
    logic               tone;
    logic [UNITS_W-1:0] units;
    logic [DUR_W-1:0]   dur_ms;
    logic               last;
  } key_seg_t;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_ONE
  } row_check_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    row_check_t        check;
    key_seg_t          seg;
  } char_row_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr   = '0;
  logic [CFG_DW-1:0]     cfg_pwdata  = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  // Symbol codes by (char - space): LSB first, 1 = dash, top 1 bit ends the code
  logic [7:0] morse_codes [NUM_CODES] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd115, 8'd49,  8'd106, 8'd41,
    8'd63,  8'd62,  8'd60,  8'd56,  8'd48,  8'd32,  8'd33,  8'd35,
    8'd39,  8'd47,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd76,
    8'd0,   8'd6,   8'd17,  8'd21,  8'd9,   8'd2,   8'd20,  8'd11,
    8'd16,  8'd4,   8'd30,  8'd13,  8'd18,  8'd7,   8'd5,   8'd15,
    8'd22,  8'd27,  8'd10,  8'd8,   8'd3,   8'd12,  8'd24,  8'd14,
    8'd25,  8'd29,  8'd19
  };

  key_seg_t              pending_segs[$];
  char_row_t             char_rows[$];
  logic [UNIT_MS_W-1:0]  unit_ms_shadow;
  int                    fail_count = 0;
  int                    cycle_count = 0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  bit                    quiet_run = 1'b0;

  morse_keyer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Build one expected segment at the current unit length
  function automatic key_seg_t make_seg(logic tone, logic [UNITS_W-1:0] units, logic last);
    key_seg_t s;
    int       ms;
    ms       = int'(units) * int'(unit_ms_shadow);
    s.tone   = tone;
    s.units  = units;
    s.dur_ms = ms[DUR_W-1:0];
    s.last   = last;
    return s;
  endfunction

  // Queue the key segments for one character; return how many
  function automatic int predict_key_segs(logic [CHAR_W-1:0] ch_in);
    logic [CHAR_W-1:0] ch;
    logic [7:0]        code;
    int                idx;
    int                n;
    ch = ch_in;
    n  = 0;
    if (ch[7] || ch < CH_SPACE) return 0;
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ch = ch - CH_FOLD;
    idx = int'(ch - CH_SPACE);
    if (idx >= NUM_CODES) return 0;
    if (idx == 0) begin
      pending_segs.push_back(make_seg(1'b0, U_WORD, 1'b1));
      return 1;
    end
    code = morse_codes[idx];
    // one tone and one gap per symbol, dash on a set bit
    while ((code & 8'hFE) != 0 && n < 12) begin
      pending_segs.push_back(make_seg(1'b1, code[0] ? U_DASH : U_DOT, 1'b0));
      pending_segs.push_back(make_seg(1'b0, U_GAP, 1'b0));
      n    = n + 2;
      code = code >> 1;
    end
    pending_segs.push_back(make_seg(1'b0, U_LETTER, 1'b1));
    return n + 1;
  endfunction

  // Result side: random stall bursts, none in the quiet run
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet_run && $urandom_range(99, 0) < recv_idle_pct) begin
      stall_left <= $urandom_range(5, 0);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted segment with the oldest expectation
  always @(posedge clk) begin
    key_seg_t got;
    key_seg_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.tone   = out_tdata[0];
      got.units  = out_tdata[3:1];
      got.dur_ms = out_tdata[13:4];
      got.last   = out_tlast;
      if (pending_segs.size() == 0) begin
        $error("unexpected segment: tone_on %0d units %0d duration_ms %0d last %0d",
               got.tone, got.units, got.dur_ms, got.last);
        fail_count++;
      end else begin
        want = pending_segs.pop_front();
        if (got.tone !== want.tone) begin
          $error("tone_on: expected %0d, got %0d", want.tone, got.tone);
          fail_count++;
        end
        if (got.units !== want.units) begin
          $error("units: expected %0d, got %0d", want.units, got.units);
          fail_count++;
        end
        if (got.dur_ms !== want.dur_ms) begin
          $error("duration_ms: expected %0d, got %0d", want.dur_ms, got.dur_ms);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  // Hold one character request until the keyer takes it
  task automatic send_char(logic [CHAR_W-1:0] ch);
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid for a random burst now and then
  task automatic send_gap();
    if (!quiet_run && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Let every expected segment drain, then let silent characters settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Two-phase register access; returns read data from the access cycle
  task automatic cfg_access(logic wr, logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data,
                            output logic [CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata       = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Read back unit_ms and compare with the shadow copy
  task automatic check_unit_ms();
    logic [CFG_DW-1:0] rd;
    cfg_access(1'b0, REG_UNIT_MS, '0, rd);
    if (rd !== CFG_DW'(unit_ms_shadow)) begin
      $error("unit_ms: expected %0d, got %0d", unit_ms_shadow, rd);
      fail_count++;
    end
  endtask

  task automatic write_unit_ms(logic [UNIT_MS_W-1:0] val);
    logic [CFG_DW-1:0] rd;
    cfg_access(1'b1, REG_UNIT_MS, CFG_DW'(val), rd);
    unit_ms_shadow = val;
    check_unit_ms();
  endtask

  function automatic void add_row(logic [CHAR_W-1:0] ch, row_check_t check, int tone,
                                  int units, int dur, int last);
    char_row_t r;
    r.ch          = ch;
    r.check       = check;
    r.seg.tone    = tone[0];
    r.seg.units   = UNITS_W'(units);
    r.seg.dur_ms  = DUR_W'(dur);
    r.seg.last    = last[0];
    char_rows.push_back(r);
  endfunction

  // Mostly letters, digits and punctuation, with some raw bytes as noise
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(99, 0);
    if (r < 40) return CHAR_W'($urandom_range(8'h5A, 8'h41));
    if (r < 55) return CHAR_W'($urandom_range(8'h7A, 8'h61));
    if (r < 75) return CHAR_W'($urandom_range(8'h40, 8'h21));
    if (r < 80) return CH_SPACE;
    return CHAR_W'($urandom_range(255, 0));
  endfunction

  initial begin
    logic [CFG_DW-1:0]    rd;
    logic [UNIT_MS_W-1:0] run_unit;
    int                   keyed;

    unit_ms_shadow = UNIT_MS_RESET;

    // Directed table, checked at the reset unit length of 60 ms
    add_row(8'h00, CHK_NONE,    0, 0, 0,    0);
    add_row(8'h1F, CHK_NONE,    0, 0, 0,    0);
    add_row(8'h20, CHK_ONE,     0, 4, 240,  1);
    add_row(8'h21, CHK_ONE,     0, 2, 120,  1);
    add_row(8'h3A, CHK_ONE,     0, 2, 120,  1);
    add_row(8'h40, CHK_ONE,     0, 2, 120,  1);
    add_row(8'h5B, CHK_NONE,    0, 0, 0,    0);
    add_row(8'h60, CHK_NONE,    0, 0, 0,    0);
    add_row(8'h7B, CHK_NONE,    0, 0, 0,    0);
    add_row(8'h7F, CHK_NONE,    0, 0, 0,    0);
    add_row(8'h80, CHK_NONE,    0, 0, 0,    0);
    add_row(8'hFF, CHK_NONE,    0, 0, 0,    0);
    add_row(8'h2C, CHK_PREDICT, 0, 0, 0,    0);
    add_row(8'h2E, CHK_PREDICT, 0, 0, 0,    0);
    add_row(8'h3F, CHK_PREDICT, 0, 0, 0,    0);
    add_row(8'h30, CHK_PREDICT, 0, 0, 0,    0);
    add_row(8'h35, CHK_PREDICT, 0, 0, 0,    0);
    add_row(8'h41, CHK_PREDICT, 0, 0, 0,    0);
    add_row(8'h61, CHK_PREDICT, 0, 0, 0,    0);
    add_row(8'h45, CHK_PREDICT, 0, 0, 0,    0);
    add_row(8'h54, CHK_PREDICT, 0, 0, 0,    0);
    add_row(8'h51, CHK_PREDICT, 0, 0, 0,    0);
    add_row(8'h5A, CHK_PREDICT, 0, 0, 0,    0);
    add_row(8'h7A, CHK_PREDICT, 0, 0, 0,    0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_unit_ms();

    send_idle_pct = 20;
    recv_idle_pct = 20;
    foreach (char_rows[i]) begin
      send_char(char_rows[i].ch);
      case (char_rows[i].check)
        CHK_ONE:     pending_segs.push_back(char_rows[i].seg);
        CHK_PREDICT: void'(predict_key_segs(char_rows[i].ch));
        default:     ;
      endcase
      send_gap();
    end
    wait_drained();

    // Unmapped address: write is dropped
    cfg_access(1'b1, REG_UNMAPPED, CFG_DW'(8'hA5), rd);
    check_unit_ms();

    // Random text under several unit lengths, extremes first, quiet last
    for (int run = 0; run < NUM_RUNS; run++) begin
      case (run)
        0:       run_unit = 8'd1;
        1:       run_unit = 8'd255;
        2:       run_unit = 8'd0;
        default: run_unit = UNIT_MS_W'($urandom_range(255, 1));
      endcase
      write_unit_ms(run_unit);
      quiet_run     = (run == NUM_RUNS - 1);
      send_idle_pct = 10 * $urandom_range(4, 0);
      recv_idle_pct = 10 * $urandom_range(4, 0);
      keyed = 0;
      while (keyed < ITEMS_PER_RUN) begin
        logic [CHAR_W-1:0] ch;
        ch = pick_char();
        send_char(ch);
        if (predict_key_segs(ch) != 0) keyed++;
        send_gap();
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
